/* src/pag_pkg.sv */
// shared types and constants for the preferential attachment graph growth core
`timescale 1ns / 1ps

package pag_pkg;

	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int EPN_W      = 4;
	localparam int RW_W       = 31;
	localparam int STATUS_W   = 3;
	localparam int NODE_OUT_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NODES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_NODES     = 2'd2;

	localparam logic [CFG_W-1:0] TOTAL_NODES_RST    = 13'd16;
	localparam logic [EPN_W-1:0] EDGES_PER_NODE_RST = 4'd2;
	localparam logic [CFG_W-1:0] SEED_NODES_RST     = 13'd3;

	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_GROW    = 1'b1;

	localparam logic [STATUS_W-1:0] ST_RESTART = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RING    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LINK    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD     = 3'd5;

	typedef struct packed {
		logic            opcode;
		logic [RW_W-1:0] random_word;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [NODE_OUT_W-1:0] source_node;
		logic [NODE_OUT_W-1:0] target_node;
	} out_word_t;

	typedef struct packed {
		logic [NODE_OUT_W-1:0] source;
		logic [NODE_OUT_W-1:0] target;
	} edge_t;

endpackage

/* src/pag_edge_mem.sv */
// edge list storage: source and target memories, one write and one registered read each
`timescale 1ns / 1ps

module pag_edge_mem #(
	parameter int DEPTH = 32768
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  pag_pkg::edge_t                   wr_edge,
	input  logic [$clog2(DEPTH)-1:0]         rd_src_addr,
	input  logic [$clog2(DEPTH)-1:0]         rd_tgt_addr,
	output logic [pag_pkg::NODE_OUT_W-1:0]   rd_src,
	output logic [pag_pkg::NODE_OUT_W-1:0]   rd_tgt
);
	import pag_pkg::*;

	logic [NODE_OUT_W-1:0] src_mem [DEPTH];
	logic [NODE_OUT_W-1:0] tgt_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			src_mem[wr_addr] <= wr_edge.source;
		end
		rd_src <= src_mem[rd_src_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tgt_mem[wr_addr] <= wr_edge.target;
		end
		rd_tgt <= tgt_mem[rd_tgt_addr];
	end

endmodule

/* src/pag_mod_div.sv */
// iterative restoring modulo unit, one remainder bit per cycle
`timescale 1ns / 1ps

module pag_mod_div #(
	parameter int DSR_W = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pag_pkg::RW_W-1:0] dividend,
	input  logic [DSR_W-1:0]         divisor,
	output logic                     done,
	output logic [DSR_W-1:0]         remainder
);
	import pag_pkg::*;

	localparam int CNT_W = $clog2(RW_W + 1);

	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [RW_W-1:0]  dvd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSR_W:0]   trial;
	logic             fits;
	logic [DSR_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[RW_W-1]};
		fits     = trial >= {1'b0, dsr_q};
		rem_next = fits ? DSR_W'(trial - {1'b0, dsr_q}) : DSR_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* src/preferential_attachment_graph_growth_core.sv */
// preferential attachment graph growth core, top level. Each accepted word is a restart or one
// growth step and yields exactly one result word. Restart, bad-config and ring steps go from the
// decode state straight to the emit state, a finished step found after the ring through the check
// state. A link step passes the check, modulo, slot, candidate and scan states: the modulo unit
// reduces the random word modulo twice the committed edge count, the chosen endpoint is then
// read, and the pending targets of the current node are then read back one per cycle from the
// target memory to reject duplicates. A result waits in the output register while the next word
// is already being worked on; the next word can be taken in the cycle after a result is
// registered. The edge memories are not cleared at reset; only entries written since are read.
`timescale 1ns / 1ps

module preferential_attachment_graph_growth_core #(
	parameter int MAX_NODES = 4096,
	parameter int MAX_LINKS = 8,
	parameter int MAX_EDGES = 32768
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pag_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pag_pkg::out_word_t            out_data,
	input  logic                          cfg_we,
	input  logic [pag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pag_pkg::CFG_W-1:0]     cfg_data
);
	import pag_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES + 2);
	localparam int LNK_W  = $clog2(MAX_LINKS + 1);
	localparam int CE_W   = $clog2(MAX_EDGES + MAX_LINKS + 1);
	localparam int AW     = $clog2(MAX_EDGES);
	localparam int DSR_W  = CE_W + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_SLOT   = 3'd4;
	localparam logic [2:0] S_CAND   = 3'd5;
	localparam logic [2:0] S_SCAN   = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] cfg_total_q;
	logic [EPN_W-1:0] cfg_epn_q;
	logic [CFG_W-1:0] cfg_seed_q;
	logic [CE_W-1:0]  committed_q;
	logic [NODE_W-1:0] node_q;
	logic [LNK_W-1:0] links_q;
	logic [LNK_W-1:0] k_q;
	logic             cmp_v_q;
	logic             out_valid_q;

	in_word_t              in_q;
	out_word_t             res_q;
	out_word_t             out_q;
	logic [DSR_W-1:0]      slot_q;
	logic                  sel_src_q;
	logic [NODE_OUT_W-1:0] cand_q;

	logic                  grow;
	logic                  cfg_bad;
	logic                  in_ring;
	logic                  ce_full;
	logic                  shrink;
	logic [CE_W:0]         idx_full;
	logic                  check_done;
	logic [NODE_W-1:0]     node_inc;
	logic [NODE_W-1:0]     ring_next;
	logic [LNK_W-1:0]      links_inc;
	logic                  link_full;
	logic                  slot_lo;
	logic                  scan_issue;
	logic                  scan_dup;
	logic                  scan_end;
	logic                  link_wr;
	logic                  out_free;
	logic                  res_load;
	out_word_t             res_next;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	edge_t                 mem_wedge;
	logic [AW-1:0]         rd_src_addr;
	logic [AW-1:0]         rd_tgt_addr;
	logic [NODE_OUT_W-1:0] rd_src;
	logic [NODE_OUT_W-1:0] rd_tgt;

	logic                  div_start;
	logic                  div_done;
	logic [DSR_W-1:0]      div_rem;

	always_comb begin
		grow    = in_q.opcode == OP_GROW;
		cfg_bad = (cfg_epn_q == '0) || (cfg_seed_q == '0) || (cfg_total_q == '0) ||
			(CFG_W'(cfg_epn_q) > cfg_seed_q) || (32'(cfg_epn_q) > 32'(MAX_LINKS)) ||
			(32'(cfg_seed_q) > 32'(MAX_NODES)) || (32'(cfg_total_q) > 32'(MAX_NODES));
		in_ring    = 32'(node_q) < 32'(cfg_seed_q);
		ce_full    = 32'(committed_q) >= 32'(MAX_EDGES);
		shrink     = 32'(links_q) >= 32'(cfg_epn_q);
		idx_full   = (CE_W + 1)'(committed_q) + (CE_W + 1)'(links_q);
		check_done = (32'(node_q) >= 32'(cfg_total_q)) || (committed_q == '0) ||
			(32'(idx_full) >= 32'(MAX_EDGES));
		node_inc   = node_q + 1'b1;
		ring_next  = (32'(node_inc) >= 32'(cfg_seed_q)) ? '0 : node_inc;
		links_inc  = links_q + 1'b1;
		link_full  = 32'(links_inc) >= 32'(cfg_epn_q);
		slot_lo    = slot_q < DSR_W'(committed_q);
		scan_issue = k_q < links_q;
		scan_dup   = cmp_v_q && (rd_tgt == cand_q);
		scan_end   = !cmp_v_q && !scan_issue;
		link_wr    = (state_q == S_SCAN) && !scan_dup && scan_end;
		out_free   = !out_valid_q || !out_stall;
		div_start  = (state_q == S_CHECK) && !check_done;
	end

	// edge memory access
	always_comb begin
		mem_we = ((state_q == S_DECIDE) && grow && !cfg_bad && in_ring && !ce_full) || link_wr;
		if (state_q == S_DECIDE) begin
			mem_waddr        = AW'(committed_q);
			mem_wedge.source = NODE_OUT_W'(node_q);
			mem_wedge.target = NODE_OUT_W'(ring_next);
		end else begin
			mem_waddr        = AW'(idx_full);
			mem_wedge.source = NODE_OUT_W'(node_q);
			mem_wedge.target = cand_q;
		end
		rd_src_addr = AW'(slot_q);
		if (state_q == S_SCAN) begin
			rd_tgt_addr = AW'(committed_q + CE_W'(k_q));
		end else begin
			rd_tgt_addr = AW'(slot_q - DSR_W'(committed_q));
		end
	end

	always_comb begin
		res_load = 1'b0;
		res_next = '0;
		unique case (state_q)
			S_DECIDE: begin
				res_load = 1'b1;
				priority if (!grow) begin
					res_next.status = ST_RESTART;
				end else if (cfg_bad) begin
					res_next.status = ST_BAD;
				end else if (in_ring) begin
					if (ce_full) begin
						res_next.status = ST_DONE;
					end else begin
						res_next.status      = ST_RING;
						res_next.source_node = NODE_OUT_W'(node_q);
						res_next.target_node = NODE_OUT_W'(ring_next);
					end
				end else begin
					res_load = 1'b0;
				end
			end
			S_CHECK: begin
				res_load        = check_done;
				res_next.status = ST_DONE;
			end
			S_SCAN: begin
				if (scan_dup) begin
					res_load        = 1'b1;
					res_next.status = ST_DUP;
				end else if (scan_end) begin
					res_load             = 1'b1;
					res_next.status      = ST_LINK;
					res_next.source_node = NODE_OUT_W'(node_q);
					res_next.target_node = cand_q;
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_total_q <= TOTAL_NODES_RST;
			cfg_epn_q   <= EDGES_PER_NODE_RST;
			cfg_seed_q  <= SEED_NODES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_NODES:    cfg_total_q <= cfg_data;
				CFG_EDGES_PER_NODE: cfg_epn_q   <= cfg_data[EPN_W-1:0];
				CFG_SEED_NODES:     cfg_seed_q  <= cfg_data;
				default:            cfg_total_q <= cfg_total_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			committed_q <= '0;
			node_q      <= '0;
			links_q     <= '0;
			k_q         <= '0;
			cmp_v_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					priority if (!grow) begin
						committed_q <= '0;
						node_q      <= '0;
						links_q     <= '0;
						state_q     <= S_EMIT;
					end else if (cfg_bad) begin
						state_q <= S_EMIT;
					end else if (in_ring) begin
						if (!ce_full) begin
							committed_q <= committed_q + 1'b1;
							node_q      <= node_inc;
						end
						state_q <= S_EMIT;
					end else begin
						// edges per node shrunk to or below what this node already made
						if (shrink) begin
							committed_q <= committed_q + CE_W'(links_q);
							links_q     <= '0;
							node_q      <= node_inc;
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= check_done ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					state_q <= S_CAND;
				end
				S_CAND: begin
					k_q     <= '0;
					cmp_v_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cmp_v_q <= scan_issue;
					if (scan_issue) begin
						k_q <= k_q + 1'b1;
					end
					if (scan_dup) begin
						state_q <= S_EMIT;
					end else if (scan_end) begin
						if (link_full) begin
							committed_q <= committed_q + CE_W'(links_inc);
							links_q     <= '0;
							node_q      <= node_inc;
						end else begin
							links_q <= links_inc;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			in_q <= in_data;
		end
		if (res_load) begin
			res_q <= res_next;
		end
		if ((state_q == S_DIV) && div_done) begin
			slot_q <= div_rem;
		end
		if (state_q == S_SLOT) begin
			sel_src_q <= slot_lo;
		end
		if (state_q == S_CAND) begin
			cand_q <= sel_src_q ? rd_src : rd_tgt;
		end
		if ((state_q == S_EMIT) && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	pag_mod_div #(
		.DSR_W(DSR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_q.random_word),
		.divisor  ({committed_q, 1'b0}),
		.done     (div_done),
		.remainder(div_rem)
	);

	pag_edge_mem #(
		.DEPTH(MAX_EDGES)
	) u_mem (
		.clk        (clk),
		.wr_en      (mem_we),
		.wr_addr    (mem_waddr),
		.wr_edge    (mem_wedge),
		.rd_src_addr(rd_src_addr),
		.rd_tgt_addr(rd_tgt_addr),
		.rd_src     (rd_src),
		.rd_tgt     (rd_tgt)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DECIDE))
		else $error("accepted word not taken into decode");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(links_q) < 32'(MAX_LINKS))
		else $error("pending link count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("modulo result outside of its wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
		else $error("output word appeared without a finished step");

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(node_q) <= 32'(MAX_NODES + 1))
		else $error("node counter out of range");

endmodule
